// ----- hdl/sct_pkg.sv -----
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and codes for the Contact header tokenizer.
// ----------------------------------------------------------------------------
package sct_pkg;

    // Default depth of the queue between classifier and tokenizer core
    localparam int unsigned SCT_QUEUE_DEPTH = 4;

    // Byte classes produced by the front classifier
    typedef enum logic [3:0] {
        CH_OTHER  = 4'd0,
        CH_COMMA  = 4'd1,
        CH_SEMI   = 4'd2,
        CH_LT     = 4'd3,
        CH_GT     = 4'd4,
        CH_QUOTE  = 4'd5,
        CH_BSLASH = 4'd6,
        CH_COLON  = 4'd7,
        CH_AT     = 4'd8,
        CH_EQ     = 4'd9,
        CH_SPACE  = 4'd10,
        CH_TAB    = 4'd11,
        CH_S      = 4'd12,
        CH_I      = 4'd13,
        CH_P      = 4'd14
    } t_chr;

    // One classified byte
    typedef struct packed {
        t_chr chr;
        logic last;
    } t_item;

    // URI walk phase
    typedef enum logic [3:0] {
        PH_NAME      = 4'd0,
        PH_SCHEME    = 4'd1,
        PH_USERHOST  = 4'd2,
        PH_HOST      = 4'd3,
        PH_HOSTWSP   = 4'd4,
        PH_PORT      = 4'd5,
        PH_PORTWSP   = 4'd6,
        PH_UPARAM    = 4'd7,
        PH_UPARAMWSP = 4'd8,
        PH_URIEND    = 4'd9,
        PH_HPARAM    = 4'd10
    } t_phase;

    // Quote / angle bracket tracker
    typedef enum logic [2:0] {
        QA_BASIC       = 3'd0,
        QA_QUOTED      = 3'd1,
        QA_ANGLE       = 3'd2,
        QA_ANGLE_QUOTE = 3'd3,
        QA_ESC_QUOTE   = 3'd4,
        QA_ESC_ANGLE_Q = 3'd5
    } t_qa;

    // Header parameter phase
    typedef enum logic [1:0] {
        PP_START = 2'd0,
        PP_NAME  = 2'd1,
        PP_VALUE = 2'd2
    } t_pphase;

    // Byte tags
    localparam logic [3:0] TAG_DELIM  = 4'd0;
    localparam logic [3:0] TAG_NAME   = 4'd1;
    localparam logic [3:0] TAG_USER   = 4'd2;
    localparam logic [3:0] TAG_HOST   = 4'd3;
    localparam logic [3:0] TAG_PORT   = 4'd4;
    localparam logic [3:0] TAG_UPARAM = 4'd5;
    localparam logic [3:0] TAG_PNAME  = 4'd6;
    localparam logic [3:0] TAG_PVALUE = 4'd7;
    localparam logic [3:0] TAG_SCHEME = 4'd8;

    // Contact status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NAME_QUOTE = 3'd1;
    localparam logic [2:0] ST_SECOND_LT  = 3'd2;
    localparam logic [2:0] ST_GT_FIRST   = 3'd3;
    localparam logic [2:0] ST_NOT_CLOSED = 3'd4;
    localparam logic [2:0] ST_NO_URI     = 3'd5;

    // Byte classifier
    function automatic t_chr classify(input logic [7:0] c);
        t_chr r;
        unique case (c)
            8'h2C:        r = CH_COMMA;
            8'h3B:        r = CH_SEMI;
            8'h3C:        r = CH_LT;
            8'h3E:        r = CH_GT;
            8'h22:        r = CH_QUOTE;
            8'h5C:        r = CH_BSLASH;
            8'h3A:        r = CH_COLON;
            8'h40:        r = CH_AT;
            8'h3D:        r = CH_EQ;
            8'h20:        r = CH_SPACE;
            8'h09:        r = CH_TAB;
            8'h53, 8'h73: r = CH_S;
            8'h49, 8'h69: r = CH_I;
            8'h50, 8'h70: r = CH_P;
            default:      r = CH_OTHER;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/sct_front.sv -----
// ----------------------------------------------------------------------------
// sct_front
// Input stage: takes header bytes and registers their byte class.
// ----------------------------------------------------------------------------
module sct_front
    import sct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_ready
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign load       = !r_valid || i_ready;
    assign o_s_tready = load;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_s_tvalid) begin
            r_item.chr  <= classify(i_s_tdata);
            r_item.last <= i_s_tlast;
        end
    end

endmodule

// ----- hdl/sct_queue.sv -----
// ----------------------------------------------------------------------------
// sct_queue
// Short register queue of classified bytes between front and core.
// ----------------------------------------------------------------------------
module sct_queue
    import sct_pkg::*;
#(
    parameter int unsigned DEPTH = SCT_QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hdl/sct_core.sv -----
// ----------------------------------------------------------------------------
// sct_core
// Tokenizer state machine and registered result stage.
// ----------------------------------------------------------------------------
module sct_core
    import sct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast
);

    t_phase      r_phase, n_phase;
    t_qa         r_qa, n_qa;
    logic [2:0]  r_cnt, n_cnt;
    t_pphase     r_pp, n_pp;
    logic [2:0]  r_err, n_err;

    logic        r_out_valid;
    logic [3:0]  r_tag;
    logic        r_more;
    logic [2:0]  r_status;
    logic        r_done;

    logic [3:0]  tag;
    logic        done;
    logic        more;
    logic [2:0]  status;
    logic        unq;
    logic        is_wsp;
    logic        in_params;
    logic        scheme_hit;
    logic [2:0]  trk_err;
    t_chr        c;

    assign o_pop      = i_valid && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_status, r_more, r_tag};
    assign o_m_tlast  = r_done;

    assign c         = i_item.chr;
    assign unq       = (r_qa == QA_BASIC);
    assign is_wsp    = (c == CH_SPACE) || (c == CH_TAB);
    assign in_params = (r_phase == PH_HPARAM);
    assign scheme_hit = ((r_cnt == 3'd0) && (c == CH_S)) || ((r_cnt == 3'd1) && (c == CH_I))
                     || ((r_cnt == 3'd2) && (c == CH_P)) || ((r_cnt == 3'd3) && (c == CH_COLON));

    always_comb begin
        n_phase = r_phase;
        n_qa    = r_qa;
        n_cnt   = r_cnt;
        n_pp    = r_pp;
        n_err   = r_err;
        tag     = TAG_DELIM;
        done    = 1'b0;
        more    = 1'b0;
        status  = ST_OK;
        trk_err = ST_OK;

        if (unq && c == CH_COMMA) begin
            done = 1'b1;
            more = 1'b1;
        end else if (unq && c == CH_SEMI && !in_params) begin
            if (r_phase == PH_NAME || r_phase == PH_SCHEME) begin
                n_err = (r_err == ST_OK) ? ST_NO_URI : r_err;
            end
            n_phase = PH_HPARAM;
            n_pp    = PP_START;
        end else begin
            unique case (r_phase)
                PH_NAME: begin
                    if (unq && (c == CH_LT || c == CH_GT)) begin
                        if (c == CH_LT) n_phase = PH_SCHEME;
                    end else if (unq && scheme_hit) begin
                        n_cnt = r_cnt + 3'd1;
                        tag   = TAG_SCHEME;
                        if (r_cnt == 3'd3) n_phase = PH_USERHOST;
                    end else begin
                        tag = TAG_NAME;
                    end
                end
                PH_SCHEME: begin
                    if (c == CH_COLON) n_phase = PH_USERHOST;
                    else               tag = TAG_SCHEME;
                end
                PH_USERHOST: begin
                    unique case (c)
                        CH_AT:    n_phase = PH_HOST;
                        CH_COLON: n_phase = PH_PORT;
                        CH_SEMI:  n_phase = PH_UPARAM;
                        CH_GT:    n_phase = PH_URIEND;
                        default:  tag = TAG_USER;
                    endcase
                end
                PH_HOST, PH_HOSTWSP: begin
                    if (c == CH_COLON)                    n_phase = PH_PORT;
                    else if (c == CH_SEMI)                n_phase = PH_UPARAM;
                    else if (c == CH_GT)                  n_phase = PH_URIEND;
                    else if (r_phase == PH_HOST && is_wsp) n_phase = PH_HOSTWSP;
                    else if (r_phase == PH_HOST)          tag = TAG_HOST;
                end
                PH_PORT, PH_PORTWSP: begin
                    if (c == CH_SEMI)                     n_phase = PH_UPARAM;
                    else if (c == CH_GT)                  n_phase = PH_URIEND;
                    else if (r_phase == PH_PORT && is_wsp) n_phase = PH_PORTWSP;
                    else if (r_phase == PH_PORT)          tag = TAG_PORT;
                end
                PH_UPARAM: begin
                    if (c == CH_GT)         n_phase = PH_URIEND;
                    else if (c == CH_SPACE) n_phase = PH_UPARAMWSP;
                    else                    tag = TAG_UPARAM;
                end
                PH_UPARAMWSP: begin
                    if (c == CH_GT) n_phase = PH_URIEND;
                end
                PH_HPARAM: begin
                    if (unq && c == CH_EQ) begin
                        n_pp = PP_VALUE;
                    end else if (unq && c == CH_SEMI) begin
                        n_pp = PP_START;
                    end else begin
                        if (unq && c != CH_QUOTE && r_pp == PP_START) n_pp = PP_NAME;
                        tag = (n_pp == PP_VALUE) ? TAG_PVALUE : TAG_PNAME;
                    end
                end
                default: begin
                end
            endcase

            // quote / angle tracker
            if (c == CH_QUOTE) begin
                if (in_params && (r_qa == QA_ANGLE || r_qa == QA_ANGLE_QUOTE
                                  || r_qa == QA_ESC_ANGLE_Q)) begin
                    n_qa = r_qa;
                end else begin
                    unique case (r_qa)
                        QA_BASIC:       n_qa = QA_QUOTED;
                        QA_QUOTED:      n_qa = QA_BASIC;
                        QA_ANGLE:       n_qa = QA_ANGLE_QUOTE;
                        QA_ANGLE_QUOTE: n_qa = QA_ANGLE;
                        QA_ESC_QUOTE:   n_qa = QA_QUOTED;
                        QA_ESC_ANGLE_Q: n_qa = QA_ANGLE_QUOTE;
                        default:        n_qa = QA_QUOTED;
                    endcase
                end
            end else if (c == CH_BSLASH) begin
                unique case (r_qa)
                    QA_BASIC:       n_qa = QA_BASIC;
                    QA_QUOTED:      n_qa = QA_ESC_QUOTE;
                    QA_ANGLE:       n_qa = QA_ANGLE;
                    QA_ANGLE_QUOTE: n_qa = QA_ESC_ANGLE_Q;
                    QA_ESC_QUOTE:   n_qa = QA_QUOTED;
                    QA_ESC_ANGLE_Q: n_qa = QA_ANGLE_QUOTE;
                    default:        n_qa = QA_BASIC;
                endcase
            end else if (!in_params && c == CH_LT && r_qa == QA_BASIC) begin
                n_qa = QA_ANGLE;
            end else if (!in_params && c == CH_LT && r_qa == QA_ANGLE) begin
                n_qa    = QA_ANGLE;
                trk_err = ST_SECOND_LT;
            end else if (!in_params && c == CH_GT && r_qa == QA_BASIC) begin
                n_qa    = QA_BASIC;
                trk_err = ST_GT_FIRST;
            end else if (!in_params && c == CH_GT && r_qa == QA_ANGLE) begin
                n_qa = QA_BASIC;
            end else if (r_qa == QA_ESC_QUOTE) begin
                n_qa = QA_QUOTED;
            end else if (r_qa == QA_ESC_ANGLE_Q) begin
                n_qa = QA_ANGLE_QUOTE;
            end
            if (n_err == ST_OK) n_err = trk_err;
        end

        if (i_item.last) done = 1'b1;

        if (done) begin
            if (!more && n_phase == PH_NAME && (n_qa == QA_QUOTED || n_qa == QA_ESC_QUOTE)) begin
                status = ST_NAME_QUOTE;
            end else if (n_err != ST_OK) begin
                status = n_err;
            end else if (!more && n_phase != PH_HPARAM && n_qa != QA_BASIC) begin
                status = ST_NOT_CLOSED;
            end else if (n_phase == PH_NAME || n_phase == PH_SCHEME) begin
                status = ST_NO_URI;
            end
            n_phase = PH_NAME;
            n_qa    = QA_BASIC;
            n_cnt   = 3'd0;
            n_pp    = PP_START;
            n_err   = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NAME;
            r_qa        <= QA_BASIC;
            r_cnt       <= 3'd0;
            r_pp        <= PP_START;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_qa    <= n_qa;
                r_cnt   <= n_cnt;
                r_pp    <= n_pp;
                r_err   <= n_err;
            end
            if (!r_out_valid || i_m_tready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tag    <= tag;
            r_more   <= more;
            r_status <= status;
            r_done   <= done;
        end
    end

endmodule

// ----- hdl/sip_contact_header_tokenizer.sv -----
// ----------------------------------------------------------------------------
// sip_contact_header_tokenizer
// Tags each byte of a Contact header line with its role and reports a
// status at the end of each contact.
// ----------------------------------------------------------------------------
//
//  channel   dir  tdata                               tlast         tuser
//  -------   ---  ----------------------------------  ------------  -----
//  s (in)    in   [7:0] byte_req                      last          -
//  m (out)   out  [3:0] tag, [4] more_contacts,       contact_done  -
//                 [7:5] status
//
//  One result item per input item, one item per cycle sustained while neither side stalls.
//  Path: front register, queue, core output register.
//  The front takes bytes as long as the queue has room; the core pops the
//  queue only when its output register is free or being drained, so either
//  side can stall without stopping the other until the queue fills.
//  Synchronous active-low reset returns the tokenizer to the start of a
//  contact and empties the queue.
//
module sip_contact_header_tokenizer
    import sct_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = SCT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,     // [7:0] byte_req
    input  logic        i_s_tlast,     // last byte of the header line
    // tagged result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,     // [3:0] tag, [4] more_contacts, [7:5] status
    output logic        o_m_tlast      // contact_done
);

    logic  front_valid;
    t_item front_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  q_pop;

    // classify each byte and register it
    sct_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_valid    (front_valid),
        .o_item     (front_item),
        .i_ready    (q_ready)
    );

    // decoupling queue
    sct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // tokenizer state and result register
    sct_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- bench/sct_checker.sv -----
// ----------------------------------------------------------------------------
// sct_checker
// Watches both streams of the Contact header tokenizer, keeps its own
// tokenizer state, predicts the tag and contact status of every accepted
// byte and compares each result item with the oldest prediction.
// ----------------------------------------------------------------------------
module sct_checker
    import sct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,      // [7:0] byte_req
    input  logic       i_s_tlast,      // last byte of the header line
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,      // [3:0] tag, [4] more_contacts, [7:5] status
    input  logic       i_m_tlast,      // contact_done
    output int         o_fail_count,
    output int         o_pending,
    output int         o_byte_count,
    output int         o_contact_count,
    output int         o_error_count,
    output int         o_comma_count
);

    localparam int MAX_REPORTS = 40;

    localparam logic [7:0] BY_COMMA  = 8'h2C;
    localparam logic [7:0] BY_SEMI   = 8'h3B;
    localparam logic [7:0] BY_LT     = 8'h3C;
    localparam logic [7:0] BY_GT     = 8'h3E;
    localparam logic [7:0] BY_QUOTE  = 8'h22;
    localparam logic [7:0] BY_BSLASH = 8'h5C;
    localparam logic [7:0] BY_COLON  = 8'h3A;
    localparam logic [7:0] BY_AT     = 8'h40;
    localparam logic [7:0] BY_EQ     = 8'h3D;
    localparam logic [7:0] BY_SPACE  = 8'h20;
    localparam logic [7:0] BY_TAB    = 8'h09;

    // scheme letters, first letter in the top byte
    localparam logic [31:0] SCHEME_TXT = "SIP:";

    typedef struct packed {
        logic       done;
        logic [2:0] status;
        logic       more;
        logic [3:0] tag;
    } t_tok;

    // predicted tokenizer state
    t_phase     phase_st;
    t_qa        qa_st;
    t_pphase    pp_st;
    logic [2:0] sip_cnt;
    logic [2:0] err_st;

    t_tok tok_q[$];
    t_tok want;

    int fail_cnt    = 0;
    int pend_cnt    = 0;
    int byte_cnt    = 0;
    int result_cnt  = 0;
    int contact_cnt = 0;
    int error_cnt   = 0;
    int comma_cnt   = 0;

    assign o_fail_count    = fail_cnt;
    assign o_pending       = pend_cnt;
    assign o_byte_count    = byte_cnt;
    assign o_contact_count = contact_cnt;
    assign o_error_count   = error_cnt;
    assign o_comma_count   = comma_cnt;

    function automatic void reset_state();
        phase_st = PH_NAME;
        qa_st    = QA_BASIC;
        pp_st    = PP_START;
        sip_cnt  = '0;
        err_st   = ST_OK;
    endfunction

    // first error of a contact sticks
    function automatic void latch_error(input logic [2:0] e);
        if (err_st == ST_OK) err_st = e;
    endfunction

    // quote / angle tracker; in header params '<' '>' are plain bytes
    function automatic t_qa qa_next(input t_qa q, input logic [7:0] c, input logic in_hp,
                                    output logic [2:0] err);
        t_qa r;
        err = ST_OK;
        r   = q;
        if (c == BY_QUOTE) begin
            if (in_hp && (q == QA_ANGLE || q == QA_ANGLE_QUOTE || q == QA_ESC_ANGLE_Q)) begin
                r = q;
            end else begin
                case (q)
                    QA_BASIC:       r = QA_QUOTED;
                    QA_QUOTED:      r = QA_BASIC;
                    QA_ANGLE:       r = QA_ANGLE_QUOTE;
                    QA_ANGLE_QUOTE: r = QA_ANGLE;
                    QA_ESC_QUOTE:   r = QA_QUOTED;
                    default:        r = QA_ANGLE_QUOTE;
                endcase
            end
        end else if (c == BY_BSLASH) begin
            case (q)
                QA_QUOTED:      r = QA_ESC_QUOTE;
                QA_ANGLE_QUOTE: r = QA_ESC_ANGLE_Q;
                QA_ESC_QUOTE:   r = QA_QUOTED;
                QA_ESC_ANGLE_Q: r = QA_ANGLE_QUOTE;
                default:        r = q;
            endcase
        end else if (!in_hp && c == BY_LT && (q == QA_BASIC || q == QA_ANGLE)) begin
            if (q == QA_ANGLE) err = ST_SECOND_LT;
            r = QA_ANGLE;
        end else if (!in_hp && c == BY_GT && (q == QA_BASIC || q == QA_ANGLE)) begin
            if (q == QA_BASIC) err = ST_GT_FIRST;
            r = QA_BASIC;
        end else if (q == QA_ESC_QUOTE) begin
            r = QA_QUOTED;
        end else if (q == QA_ESC_ANGLE_Q) begin
            r = QA_ANGLE_QUOTE;
        end
        return r;
    endfunction

    // one byte through the predicted tokenizer
    task automatic tokenize_byte(input logic [7:0] c, input logic lst, output t_tok r);
        t_phase     ph;
        t_qa        q;
        logic       unq;
        logic       wsp;
        logic [7:0] uc;
        logic [2:0] e;
        int         idx;
        ph  = phase_st;
        q   = qa_st;
        r   = '0;
        unq = (q == QA_BASIC);
        wsp = (c == BY_SPACE) || (c == BY_TAB);
        uc  = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
        idx = int'(sip_cnt);
        if (unq && c == BY_COMMA) begin
            r.done = 1'b1;
            r.more = 1'b1;
        end else if (unq && c == BY_SEMI && ph != PH_HPARAM) begin
            if (ph <= PH_SCHEME) latch_error(ST_NO_URI);
            phase_st = PH_HPARAM;
            pp_st    = PP_START;
        end else begin
            case (ph)
                PH_NAME: begin
                    if (unq && (c == BY_LT || c == BY_GT)) begin
                        if (c == BY_LT) phase_st = PH_SCHEME;
                    end else if (unq && c != BY_QUOTE && idx < 4 &&
                                 uc == SCHEME_TXT[8*(3-idx) +: 8]) begin
                        sip_cnt = sip_cnt + 3'd1;
                        r.tag   = TAG_SCHEME;
                        if (sip_cnt == 3'd4) phase_st = PH_USERHOST;
                    end else begin
                        r.tag = TAG_NAME;
                    end
                end
                PH_SCHEME: begin
                    if (c == BY_COLON) phase_st = PH_USERHOST;
                    else r.tag = TAG_SCHEME;
                end
                PH_USERHOST: begin
                    if (c == BY_AT) phase_st = PH_HOST;
                    else if (c == BY_COLON) phase_st = PH_PORT;
                    else if (c == BY_SEMI) phase_st = PH_UPARAM;
                    else if (c == BY_GT) phase_st = PH_URIEND;
                    else r.tag = TAG_USER;
                end
                PH_HOST, PH_HOSTWSP: begin
                    if (c == BY_COLON) phase_st = PH_PORT;
                    else if (c == BY_SEMI) phase_st = PH_UPARAM;
                    else if (c == BY_GT) phase_st = PH_URIEND;
                    else if (ph == PH_HOST && wsp) phase_st = PH_HOSTWSP;
                    else if (ph == PH_HOST) r.tag = TAG_HOST;
                end
                PH_PORT, PH_PORTWSP: begin
                    if (c == BY_SEMI) phase_st = PH_UPARAM;
                    else if (c == BY_GT) phase_st = PH_URIEND;
                    else if (ph == PH_PORT && wsp) phase_st = PH_PORTWSP;
                    else if (ph == PH_PORT) r.tag = TAG_PORT;
                end
                PH_UPARAM: begin
                    // only a space, not a tab, closes the URI params
                    if (c == BY_GT) phase_st = PH_URIEND;
                    else if (c == BY_SPACE) phase_st = PH_UPARAMWSP;
                    else r.tag = TAG_UPARAM;
                end
                PH_UPARAMWSP: begin
                    if (c == BY_GT) phase_st = PH_URIEND;
                end
                PH_HPARAM: begin
                    if (unq && c == BY_EQ) begin
                        pp_st = PP_VALUE;
                    end else if (unq && c == BY_SEMI) begin
                        pp_st = PP_START;
                    end else begin
                        if (unq && c != BY_QUOTE && pp_st == PP_START) pp_st = PP_NAME;
                        r.tag = (pp_st == PP_VALUE) ? TAG_PVALUE : TAG_PNAME;
                    end
                end
                default: ;
            endcase
            qa_st = qa_next(q, c, ph == PH_HPARAM, e);
            if (e != ST_OK) latch_error(e);
        end
        if (lst) r.done = 1'b1;
        if (r.done) begin
            if (!r.more && phase_st == PH_NAME && (qa_st == QA_QUOTED || qa_st == QA_ESC_QUOTE))
                r.status = ST_NAME_QUOTE;
            else if (err_st != ST_OK)
                r.status = err_st;
            else if (!r.more && phase_st != PH_HPARAM && qa_st != QA_BASIC)
                r.status = ST_NOT_CLOSED;
            else if (phase_st <= PH_SCHEME)
                r.status = ST_NO_URI;
            else
                r.status = ST_OK;
            reset_state();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("result %0d: %s is %0d, expected %0d", result_cnt, what, got, exp_val);
    endtask

    always @(posedge i_clk) begin : watch
        if (!i_rst_n) begin
            reset_state();
            tok_q.delete();
            pend_cnt = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                tokenize_byte(i_s_tdata, i_s_tlast, want);
                tok_q.push_back(want);
                pend_cnt++;
                byte_cnt++;
            end
            if (i_m_tvalid && i_m_tready) begin
                if (tok_q.size() == 0) begin
                    report_mismatch("item with nothing pending, tdata", int'(i_m_tdata), -1);
                end else begin
                    want = tok_q.pop_front();
                    pend_cnt--;
                    if (i_m_tdata[3:0] !== want.tag)
                        report_mismatch("tag", int'(i_m_tdata[3:0]), int'(want.tag));
                    if (i_m_tdata[4] !== want.more)
                        report_mismatch("more_contacts", int'(i_m_tdata[4]), int'(want.more));
                    if (i_m_tdata[7:5] !== want.status)
                        report_mismatch("status", int'(i_m_tdata[7:5]), int'(want.status));
                    if (i_m_tlast !== want.done)
                        report_mismatch("contact_done", int'(i_m_tlast), int'(want.done));
                    if (want.done) begin
                        contact_cnt++;
                        if (want.status != ST_OK) error_cnt++;
                        if (want.more) comma_cnt++;
                    end
                end
                result_cnt++;
            end
        end
    end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives Contact header lines into the tokenizer: a short directed set of
// corner cases, then random lines of mostly well-formed contacts with broken
// and noisy ones mixed in, under four idle/stall mixes and a long output
// hold. The checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module tb;
    import sct_pkg::*;

    localparam int HOLD_CYCLES  = 200;  // long output hold, fills the queue
    localparam int PHASE_ITEMS  = 100;  // minimum bytes per random phase
    localparam int TAIL_CYCLES  = 20;   // settle after the last result

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = '0;        // [7:0] byte_req
    logic       i_s_tlast  = 1'b0;      // last byte of the header line
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;              // [3:0] tag, [4] more_contacts, [7:5] status
    logic       o_m_tlast;              // contact_done

    int fail_cnt;
    int pend_cnt;
    int byte_cnt;
    int contact_cnt;
    int error_cnt;
    int comma_cnt;

    // stimulus store: one byte and its tlast per entry
    logic [7:0] byte_q[$];
    bit         last_q[$];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    bit hold_req      = 1'b0;

    sip_contact_header_tokenizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    sct_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (i_s_tvalid),
        .i_s_tready      (o_s_tready),
        .i_s_tdata       (i_s_tdata),
        .i_s_tlast       (i_s_tlast),
        .i_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .i_m_tdata       (o_m_tdata),
        .i_m_tlast       (o_m_tlast),
        .o_fail_count    (fail_cnt),
        .o_pending       (pend_cnt),
        .o_byte_count    (byte_cnt),
        .o_contact_count (contact_cnt),
        .o_error_count   (error_cnt),
        .o_comma_count   (comma_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #800_000;
        $display("timeout: results still pending = %0d", pend_cnt);
        $display("** sip_contact_header_tokenizer: FAILED **");
        $finish;
    end

    // ---- stimulus builders -------------------------------------------------

    task automatic push_byte(input logic [7:0] b, input bit l);
        byte_q.push_back(b);
        last_q.push_back(l);
    endtask

    task automatic push_str(input string s);
        int k;
        for (k = 0; k < s.len(); k++) push_byte(s[k], 1'b0);
    endtask

    // letters in random case, so the scheme match sees both
    task automatic push_cased(input string s);
        int         k;
        logic [7:0] b;
        for (k = 0; k < s.len(); k++) begin
            b = s[k];
            if (b >= 8'h61 && b <= 8'h7A && $urandom_range(0, 1)) b = b - 8'd32;
            push_byte(b, 1'b0);
        end
    endtask

    // token text; s/i/p letters let display names start a scheme match
    task automatic push_word(input int lo, input int hi);
        string wc;
        int    n;
        int    k;
        wc = "abcdhsipSIPxz0129-._~";
        n  = $urandom_range(lo, hi);
        for (k = 0; k < n; k++) push_byte(wc[$urandom_range(0, wc.len() - 1)], 1'b0);
    endtask

    task automatic mark_last();
        last_q[last_q.size() - 1] = 1'b1;
    endtask

    // delimiter-heavy or fully random byte, bit 7 included
    function automatic logic [7:0] odd_byte();
        string      sp;
        logic [7:0] r;
        sp = "<>\"\\;,:@= \t";
        if ($urandom_range(0, 1)) r = sp[$urandom_range(0, sp.len() - 1)];
        else r = 8'($urandom_range(0, 255));
        return r;
    endfunction

    // Random header lines of 1..3 contacts until target more bytes are queued.
    // Most contacts are well formed: optional display name (bare or quoted,
    // maybe with an escape), '<' scheme ':' or bare sip:, user@, host,
    // port, URI param, header params. One in ten gets bytes corrupted, one
    // in ten is pure noise.
    task automatic build_lines(input int target);
        int goal;
        int nc;
        int ci;
        int form;
        int start;
        int k;
        int pos;
        bit angle;
        goal = byte_q.size() + target;
        while (byte_q.size() < goal) begin
            nc = $urandom_range(1, 3);
            for (ci = 0; ci < nc; ci++) begin
                start = byte_q.size();
                form  = $urandom_range(0, 9);
                if (form == 9) begin
                    k = $urandom_range(1, 8);
                    repeat (k) push_byte(odd_byte(), 1'b0);
                end else begin
                    angle = ($urandom_range(0, 3) != 0);
                    case ($urandom_range(0, 2))
                        1: begin
                            push_word(1, 6);
                            push_str(" ");
                        end
                        2: begin
                            push_str("\"");
                            push_word(0, 4);
                            if ($urandom_range(0, 1)) begin
                                if ($urandom_range(0, 1)) push_str("\\\"");
                                else push_str("\\\\");
                            end
                            push_word(0, 3);
                            push_str("\" ");
                        end
                        default: ;
                    endcase
                    if (angle) begin
                        push_str("<");
                        k = $urandom_range(0, 3);
                        if (k == 3) begin
                            push_word(1, 4);
                        end else begin
                            push_cased("sip");
                            if (k == 1) push_cased("s");
                        end
                        push_str(":");
                    end else begin
                        push_cased("sip:");
                    end
                    if ($urandom_range(0, 1)) begin
                        push_word(1, 6);
                        push_str("@");
                    end
                    push_word(1, 8);
                    if ($urandom_range(0, 4) == 0) begin
                        if ($urandom_range(0, 1)) push_str(" ");
                        else push_str("\t");
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        push_str(":");
                        push_word(1, 5);
                        if ($urandom_range(0, 4) == 0) push_str("\t");
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        push_str(";");
                        push_word(1, 4);
                        push_str("=");
                        push_word(0, 4);
                        if ($urandom_range(0, 3) == 0) push_str(" ");
                    end
                    if (angle) push_str(">");
                    repeat ($urandom_range(0, 2)) begin
                        push_str(";");
                        push_word(1, 5);
                        if ($urandom_range(0, 1)) begin
                            push_str("=");
                            if ($urandom_range(0, 2) == 0) begin
                                // quoted value, may hold brackets or commas
                                push_str("\"");
                                push_word(0, 3);
                                push_byte(odd_byte(), 1'b0);
                                push_word(0, 3);
                                push_str("\"");
                            end else begin
                                push_word(1, 5);
                            end
                        end
                    end
                    if (form == 8) begin
                        repeat ($urandom_range(1, 2)) begin
                            pos = start + $urandom_range(0, byte_q.size() - start - 1);
                            byte_q[pos] = odd_byte();
                        end
                    end
                end
                if (ci < nc - 1) push_str(",");
            end
            // now and then a trailing comma that is also the last byte
            if ($urandom_range(0, 9) == 0) push_str(",");
            mark_last();
        end
    endtask

    // ---- drivers -----------------------------------------------------------

    // Input side: one decision per falling edge while no byte waits, valid held until taken.
    task automatic send_queue();
        while (byte_q.size() > 0) begin
            @(negedge i_clk);
            if ($urandom_range(1, 100) <= src_idle_pct) begin
                i_s_tvalid <= 1'b0;
            end else begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= byte_q.pop_front();
                i_s_tlast  <= last_q.pop_front();
                do @(posedge i_clk); while (!o_s_tready);
            end
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
    endtask

    // Sender pause: nothing new goes in until every result is out.
    task automatic wait_drained();
        while (pend_cnt != 0) @(negedge i_clk);
    endtask

    // Output side: random stalls, plus a long hold counted here on request.
    initial begin : sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(1, 100) > snk_stall_pct);
            end
        end
    end

    // ---- sequence ----------------------------------------------------------

    initial begin : main_seq
        int phase;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases, one header line each
        push_str("\"\\\"");         // quote still open in the display name
        mark_last();
        push_str("<<>");            // second '<'
        mark_last();
        push_str(">");              // '>' before any '<'
        mark_last();
        push_str(";");              // header params with no URI
        mark_last();
        push_str("sIp:u@h:9;t,");   // bare mixed-case scheme, ends at comma
        push_str(",");              // comma that is also the last byte
        mark_last();
        push_byte(8'h00, 1'b0);     // extreme byte values
        push_byte(8'hFF, 1'b1);
        push_str("<x");             // angle never closed
        mark_last();
        send_queue();
        wait_drained();

        // random lines under each idle/stall mix
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
                default: begin src_idle_pct = 9; snk_stall_pct = 9; end
            endcase
            build_lines(PHASE_ITEMS);
            // back-pressure: output held while bytes keep coming
            if (phase == 0) hold_req = 1'b1;
            send_queue();
            wait_drained();
        end

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("run: %0d bytes tokenized, %0d contacts closed (%0d ended at a comma,",
                 byte_cnt, contact_cnt, comma_cnt);
        $display("     %0d with an error status), four idle mixes and a %0d-cycle output hold",
                 error_cnt, HOLD_CYCLES);
        if (fail_cnt == 0 && pend_cnt == 0) begin
            $display("** sip_contact_header_tokenizer: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_cnt, pend_cnt);
            $display("** sip_contact_header_tokenizer: FAILED **");
        end
        $finish;
    end

endmodule
